>>> design/assert_macros.svh
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/gpdb_pkg.sv
package gpdb_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int CH_COUNT     = 1 << CHANNEL_BITS;
	localparam int CH_MAX       = CH_COUNT - 1;
	localparam int LIN_W        = 24;
	localparam int unsigned LIN_LIMIT = 32'd1 << LIN_W;
	localparam int W_W          = 2 * CHANNEL_BITS;
	localparam int SUM_W        = W_W + 1;
	localparam int PROD_W       = W_W + LIN_W;
	localparam int REM_W        = PROD_W + 1;
	localparam int DIV_STEPS    = LIN_W;
	localparam int CODE_STEPS   = CHANNEL_BITS;
	localparam int NST          = 3 + DIV_STEPS + CODE_STEPS;

	typedef logic [CHANNEL_BITS-1:0] chan_t;
	typedef logic [LIN_W-1:0]        lin_t;
	typedef logic [W_W-1:0]          weight_t;
	typedef logic [SUM_W-1:0]        wsum_t;
	typedef lin_t                    lin_tab_t [CH_COUNT];

	typedef enum logic [2:0] {
		MODE_SRC  = 3'd0,
		MODE_DST  = 3'd1,
		MODE_OVER = 3'd2,
		MODE_IN   = 3'd3,
		MODE_OUT  = 3'd4,
		MODE_ADD  = 3'd5
	} blend_mode_t;

	// stage load enables from the pipeline control
	typedef struct packed {
		logic [NST-1:0] en;
	} pipe_ctl_t;

	function automatic logic [127:0] pow5(logic [127:0] b);
		logic [127:0] r;
		r = b * b;
		r = r * r;
		r = r * b;
		return r;
	endfunction

	function automatic logic [127:0] pow11(logic [127:0] b);
		logic [127:0] r;
		r = 128'd1;
		for (int e = 0; e < 11; e++) begin
			r = r * b;
		end
		return r;
	endfunction

	// largest n with (2n-1)^5 <= x^11 * 2^35, i.e. round(x^2.2 * 64)
	function automatic lin_tab_t build_lin_tab();
		lin_tab_t tab;
		logic [127:0] rhs;
		int unsigned lo, hi, mid;
		tab[0] = '0;
		for (int x = 1; x < CH_COUNT; x++) begin
			rhs = pow11(128'(x)) << 35;
			lo = 0;
			hi = LIN_LIMIT;
			while (hi - lo > 1) begin
				mid = lo + (hi - lo) / 2;
				if (pow5(128'(2 * mid - 1)) <= rhs) lo = mid;
				else hi = mid;
			end
			tab[x] = LIN_W'(lo);
		end
		return tab;
	endfunction

	// smallest L with L^5 >= (2c-1)^11 * 2^19, i.e. (c-0.5)^2.2 in 1/64 units
	function automatic lin_tab_t build_thr_tab();
		lin_tab_t tab;
		logic [127:0] rhs;
		int unsigned lo, hi, mid;
		tab[0] = '0;
		for (int x = 1; x < CH_COUNT; x++) begin
			rhs = pow11(128'(2 * x - 1)) << 19;
			lo = 0;
			hi = LIN_LIMIT;
			while (hi - lo > 1) begin
				mid = lo + (hi - lo) / 2;
				if (pow5(128'(mid)) >= rhs) hi = mid;
				else lo = mid;
			end
			tab[x] = LIN_W'(hi);
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TAB = build_lin_tab();
	localparam lin_tab_t THR_TAB = build_thr_tab();

endpackage

>>> design/gpdb_if.sv
// input item: source and destination pixel
interface gpdb_in_if;
	import gpdb_pkg::*;
	logic  valid;
	logic  ready;
	chan_t src_red;
	chan_t src_green;
	chan_t src_blue;
	chan_t src_alpha;
	chan_t dst_red;
	chan_t dst_green;
	chan_t dst_blue;
	chan_t dst_alpha;
	modport source (output valid, src_red, src_green, src_blue, src_alpha,
		dst_red, dst_green, dst_blue, dst_alpha, input ready);
	modport sink (input valid, src_red, src_green, src_blue, src_alpha,
		dst_red, dst_green, dst_blue, dst_alpha, output ready);
endinterface

// result item: composited pixel
interface gpdb_out_if;
	import gpdb_pkg::*;
	logic  valid;
	logic  ready;
	chan_t out_red;
	chan_t out_green;
	chan_t out_blue;
	chan_t out_alpha;
	modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

>>> design/gpdb_lane.sv
module gpdb_lane
	import gpdb_pkg::*;
(
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  chan_t     src_code,
	input  chan_t     dst_code,
	input  weight_t   wa,
	input  weight_t   wb,
	output chan_t     code
);

	lin_t                la_s1, lb_s1;
	logic [PROD_W-1:0]   pa_s2, pb_s2;
	wsum_t               sum_s2;
	wsum_t               sum_w;

	// divider pipeline, index 0 is the setup stage
	logic [REM_W-1:0]    rem_s [DIV_STEPS+1];
	wsum_t               den_s [DIV_STEPS+1];
	lin_t                quo_s [DIV_STEPS+1];

	// encode search pipeline, index 0 is the divider result
	lin_t                lin_s  [CODE_STEPS+1];
	chan_t               code_s [CODE_STEPS+1];

	assign sum_w = SUM_W'(wa) + SUM_W'(wb);

	// linearize both colors
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			la_s1 <= LIN_TAB[src_code];
			lb_s1 <= LIN_TAB[dst_code];
		end
	end

	// weight the linear values
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			pa_s2  <= PROD_W'(wa) * PROD_W'(la_s1);
			pb_s2  <= PROD_W'(wb) * PROD_W'(lb_s1);
			sum_s2 <= sum_w;
		end
	end

	// numerator with half the divisor for rounding
	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			rem_s[0] <= REM_W'(pa_s2) + REM_W'(pb_s2) + REM_W'(sum_s2 >> 1);
			den_s[0] <= sum_s2;
			quo_s[0] <= '0;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int B = DIV_STEPS - 1 - k;
		logic [REM_W-1:0] dsh;
		logic             fits;
		assign dsh  = REM_W'(den_s[k]) << B;
		assign fits = rem_s[k] >= dsh;
		always_ff @(posedge clk) begin
			if (ctl.en[3+k]) begin
				rem_s[k+1] <= fits ? rem_s[k] - dsh : rem_s[k];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= quo_s[k] | (fits ? LIN_W'(1) << B : '0);
			end
		end
	end

	assign lin_s[0]  = quo_s[DIV_STEPS];
	assign code_s[0] = '0;

	// binary search of the threshold table, msb first
	for (genvar j = 0; j < CODE_STEPS; j++) begin : g_enc
		localparam int B = CODE_STEPS - 1 - j;
		chan_t cand;
		assign cand = code_s[j] | (CHANNEL_BITS'(1) << B);
		always_ff @(posedge clk) begin
			if (ctl.en[3+DIV_STEPS+j]) begin
				lin_s[j+1]  <= lin_s[j];
				code_s[j+1] <= (lin_s[j] >= THR_TAB[cand]) ? cand : code_s[j];
			end
		end
	end

	assign code = code_s[CODE_STEPS];

endmodule

>>> design/gamma_porter_duff_blend_rgba8.sv
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined per-color divider
// and the eight-step threshold search that follows it
// reset: clears all stage valid bits and sets the blend mode to over
module gamma_porter_duff_blend_rgba8
	import gpdb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_wr_data,
	gpdb_in_if.sink           in_px,
	gpdb_out_if.source        out_px
);

	typedef struct packed {
		logic  pass;
		logic  zero;
		chan_t red;
		chan_t green;
		chan_t blue;
		chan_t alpha;
	} aux_t;

	logic [2:0]     mode_q;
	logic [NST-1:0] v_q;
	pipe_ctl_t      ctl;

	weight_t wa_c, wb_c, wa_s1, wb_s1;
	logic    pass_s1;
	chan_t   pr_s1, pg_s1, pb_s1, pa_s1;

	wsum_t         sum_c;
	logic [16:0]   t_c;
	logic [16:0]   q_c;
	aux_t          aux_c;
	aux_t          aux_s [1:NST-1];
	chan_t         code_r, code_g, code_b;

	// blend mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OVER;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// bubble-collapsing stage enables
	always_comb begin
		ctl.en[NST-1] = !v_q[NST-1] || out_px.ready;
		for (int k = NST - 2; k >= 0; k--) begin
			ctl.en[k] = !v_q[k] || ctl.en[k+1];
		end
	end

	assign in_px.ready = ctl.en[0];

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (ctl.en[0]) v_q[0] <= in_px.valid;
			for (int k = 1; k < NST; k++) begin
				if (ctl.en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// porter-duff weights in 1/65025 units
	always_comb begin
		wa_c = '0;
		wb_c = '0;
		case (mode_q)
			MODE_OVER: begin
				wa_c = W_W'(in_px.src_alpha) * W_W'(CH_MAX);
				wb_c = W_W'(in_px.dst_alpha) * W_W'(CHANNEL_BITS'(CH_MAX) - in_px.src_alpha);
			end
			MODE_IN: begin
				wa_c = W_W'(in_px.src_alpha) * W_W'(in_px.dst_alpha);
			end
			MODE_OUT: begin
				wa_c = W_W'(in_px.src_alpha) * W_W'(CHANNEL_BITS'(CH_MAX) - in_px.dst_alpha);
			end
			MODE_ADD: begin
				wa_c = W_W'(in_px.src_alpha) * W_W'(CH_MAX);
				wb_c = W_W'(in_px.dst_alpha) * W_W'(CH_MAX);
			end
			default: begin
				wa_c = '0;
				wb_c = '0;
			end
		endcase
	end

	// first stage: weights and pass-through pixel
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			wa_s1   <= wa_c;
			wb_s1   <= wb_c;
			pass_s1 <= (mode_q == MODE_SRC) || (mode_q == MODE_DST);
			pr_s1   <= (mode_q == MODE_SRC) ? in_px.src_red   : in_px.dst_red;
			pg_s1   <= (mode_q == MODE_SRC) ? in_px.src_green : in_px.dst_green;
			pb_s1   <= (mode_q == MODE_SRC) ? in_px.src_blue  : in_px.dst_blue;
			pa_s1   <= (mode_q == MODE_SRC) ? in_px.src_alpha : in_px.dst_alpha;
		end
	end

	// output alpha: round(sum / 255) by reciprocal, saturated
	always_comb begin
		sum_c = SUM_W'(wa_s1) + SUM_W'(wb_s1);
		t_c   = 17'(sum_c) + 17'(CH_MAX / 2);
		q_c   = (t_c + (t_c >> 8) + 17'd1) >> 8;
		aux_c.pass  = pass_s1;
		aux_c.zero  = (sum_c == '0);
		aux_c.red   = pr_s1;
		aux_c.green = pg_s1;
		aux_c.blue  = pb_s1;
		aux_c.alpha = pass_s1 ? pa_s1 :
			(q_c > 17'(CH_MAX)) ? CHANNEL_BITS'(CH_MAX) : q_c[CHANNEL_BITS-1:0];
	end

	// side-band delay line alongside the color lanes
	always_ff @(posedge clk) begin
		if (ctl.en[1]) aux_s[1] <= aux_c;
		for (int k = 2; k < NST; k++) begin
			if (ctl.en[k]) aux_s[k] <= aux_s[k-1];
		end
	end

	// one lane per color channel
	gpdb_lane u_lane_r (
		.clk(clk), .ctl(ctl), .src_code(in_px.src_red), .dst_code(in_px.dst_red),
		.wa(wa_s1), .wb(wb_s1), .code(code_r)
	);
	gpdb_lane u_lane_g (
		.clk(clk), .ctl(ctl), .src_code(in_px.src_green), .dst_code(in_px.dst_green),
		.wa(wa_s1), .wb(wb_s1), .code(code_g)
	);
	gpdb_lane u_lane_b (
		.clk(clk), .ctl(ctl), .src_code(in_px.src_blue), .dst_code(in_px.dst_blue),
		.wa(wa_s1), .wb(wb_s1), .code(code_b)
	);

	// merge lanes with pass-through and zero-weight cases
	always_comb begin
		out_px.valid = v_q[NST-1];
		if (aux_s[NST-1].pass) begin
			out_px.out_red   = aux_s[NST-1].red;
			out_px.out_green = aux_s[NST-1].green;
			out_px.out_blue  = aux_s[NST-1].blue;
			out_px.out_alpha = aux_s[NST-1].alpha;
		end else if (aux_s[NST-1].zero) begin
			out_px.out_red   = '0;
			out_px.out_green = '0;
			out_px.out_blue  = '0;
			out_px.out_alpha = '0;
		end else begin
			out_px.out_red   = code_r;
			out_px.out_green = code_g;
			out_px.out_blue  = code_b;
			out_px.out_alpha = aux_s[NST-1].alpha;
		end
	end

endmodule

>>> design/gpdb_checker.sv
`include "assert_macros.svh"

module gpdb_checker
	import gpdb_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input chan_t out_red,
	input chan_t out_green,
	input chan_t out_blue,
	input chan_t out_alpha
);

	logic                      stall;
	logic [4*CHANNEL_BITS-1:0] out_pix;
	assign stall   = out_valid && !out_ready;
	assign out_pix = {out_red, out_green, out_blue, out_alpha};

	// a waiting result stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, stall, out_valid, "result dropped while stalled")

	// a waiting result keeps its value
	`ASSERT_NEXT(a_out_stable, clk, arst_n, stall, $stable(out_pix), "result changed while stalled")

	// an empty output stage means the whole pipeline can move
	`ASSERT_IMPL(a_ready_empty, clk, arst_n, !out_valid, in_ready, "input blocked with empty output")

	// a taken output frees every stage
	`ASSERT_IMPL(a_ready_taken, clk, arst_n, out_ready, in_ready, "input blocked while output drains")

endmodule

bind gamma_porter_duff_blend_rgba8 gpdb_checker u_gpdb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_px.ready),
	.out_valid(out_px.valid),
	.out_ready(out_px.ready),
	.out_red(out_px.out_red),
	.out_green(out_px.out_green),
	.out_blue(out_px.out_blue),
	.out_alpha(out_px.out_alpha)
);
